// ===== design/assert_macros.svh =====
// assertion macros used by the checker module
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define PIS_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// property checked on every rising edge, reset included
`define PIS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/pis_pkg.sv =====
// shared types and widths for the point-in-sector test pipeline
// no dependencies
package pis_pkg;

    localparam int CoordW   = 16;
    localparam int RadiusW  = 15;
    localparam int DiffW    = CoordW + 1;
    localparam int ProdW    = 2 * DiffW;
    localparam int CrossW   = ProdW + 1;
    localparam int SqW      = ProdW - 1;
    localparam int Dist2W   = SqW + 1;
    localparam int SqrtBits = (Dist2W + 1) / 2;
    localparam int TrialW   = Dist2W + 2;

    typedef struct packed {
        logic signed [CoordW-1:0] apex_x;
        logic signed [CoordW-1:0] apex_z;
        logic signed [CoordW-1:0] left_x;
        logic signed [CoordW-1:0] left_z;
        logic signed [CoordW-1:0] right_x;
        logic signed [CoordW-1:0] right_z;
        logic signed [CoordW-1:0] target_x;
        logic signed [CoordW-1:0] target_z;
        logic [RadiusW-1:0]       target_radius;
    } query_t;

    // item state that rides alongside the square root
    typedef struct packed {
        logic                inside_left_edge;
        logic                inside_right_edge;
        logic [Dist2W-1:0]   dist2;
        logic [RadiusW-1:0]  target_radius;
    } side_t;

    typedef struct packed {
        logic [Dist2W-1:0] sect2;
        side_t             side;
    } front_t;

    typedef struct packed {
        logic [SqrtBits-1:0] sect_r;
        side_t               side;
    } root_t;

    typedef struct packed {
        logic inside_left_edge;
        logic inside_right_edge;
        logic within_range;
        logic hit;
    } result_t;

endpackage

// ===== design/pis_front.sv =====
// front end: coordinate differences, products, cross and squared sums (3 stages)
// depends on pis_pkg
module pis_front import pis_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  query_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output front_t out_data
);

    function automatic logic signed [DiffW-1:0] sub_ext(input logic signed [CoordW-1:0] a,
                                                         input logic signed [CoordW-1:0] b);
        sub_ext = {a[CoordW-1], a} - {b[CoordW-1], b};
    endfunction

    typedef struct packed {
        logic signed [DiffW-1:0] l_dz, l_tx, l_dx, l_tz;
        logic signed [DiffW-1:0] r_dz, r_tx, r_dx, r_tz;
        logic signed [DiffW-1:0] s_dx, s_dz, t_dx, t_dz;
        logic [RadiusW-1:0]      target_radius;
    } diff_t;

    typedef struct packed {
        logic signed [ProdW-1:0] pl1, pl2, pr1, pr2;
        logic signed [ProdW-1:0] sq_sx, sq_sz, sq_tx, sq_tz;
        logic [RadiusW-1:0]      target_radius;
    } prod_t;

    logic   v1_reg, v2_reg, v3_reg;
    logic   rdy1, rdy2, rdy3;
    diff_t  d_reg, d_next;
    prod_t  p_reg, p_next;
    front_t f_reg, f_next;
    logic signed [CrossW-1:0] cross_l, cross_r;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        d_next.l_dz = sub_ext(in_data.apex_z, in_data.left_z);
        d_next.l_tx = sub_ext(in_data.target_x, in_data.left_x);
        d_next.l_dx = sub_ext(in_data.apex_x, in_data.left_x);
        d_next.l_tz = sub_ext(in_data.target_z, in_data.left_z);
        d_next.r_dz = sub_ext(in_data.right_z, in_data.apex_z);
        d_next.r_tx = sub_ext(in_data.target_x, in_data.apex_x);
        d_next.r_dx = sub_ext(in_data.right_x, in_data.apex_x);
        d_next.r_tz = sub_ext(in_data.target_z, in_data.apex_z);
        d_next.s_dx = sub_ext(in_data.left_x, in_data.apex_x);
        d_next.s_dz = sub_ext(in_data.left_z, in_data.apex_z);
        d_next.t_dx = sub_ext(in_data.apex_x, in_data.target_x);
        d_next.t_dz = sub_ext(in_data.apex_z, in_data.target_z);
        d_next.target_radius = in_data.target_radius;
    end

    always_comb begin
        p_next.pl1   = d_reg.l_dz * d_reg.l_tx;
        p_next.pl2   = d_reg.l_dx * d_reg.l_tz;
        p_next.pr1   = d_reg.r_dz * d_reg.r_tx;
        p_next.pr2   = d_reg.r_dx * d_reg.r_tz;
        p_next.sq_sx = d_reg.s_dx * d_reg.s_dx;
        p_next.sq_sz = d_reg.s_dz * d_reg.s_dz;
        p_next.sq_tx = d_reg.t_dx * d_reg.t_dx;
        p_next.sq_tz = d_reg.t_dz * d_reg.t_dz;
        p_next.target_radius = d_reg.target_radius;
    end

    // zero or negative cross product counts as inside
    always_comb begin
        cross_l = {p_reg.pl1[ProdW-1], p_reg.pl1} - {p_reg.pl2[ProdW-1], p_reg.pl2};
        cross_r = {p_reg.pr1[ProdW-1], p_reg.pr1} - {p_reg.pr2[ProdW-1], p_reg.pr2};
        f_next.side.inside_left_edge  = cross_l[CrossW-1] || (cross_l == '0);
        f_next.side.inside_right_edge = cross_r[CrossW-1] || (cross_r == '0);
        f_next.sect2      = {1'b0, p_reg.sq_sx[SqW-1:0]} + {1'b0, p_reg.sq_sz[SqW-1:0]};
        f_next.side.dist2 = {1'b0, p_reg.sq_tx[SqW-1:0]} + {1'b0, p_reg.sq_tz[SqW-1:0]};
        f_next.side.target_radius = p_reg.target_radius;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) d_reg <= d_next;
        if (rdy2 && v1_reg)   p_reg <= p_next;
        if (rdy3 && v2_reg)   f_reg <= f_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = f_reg;

endmodule

// ===== design/pis_sqrt.sv =====
// pipelined integer square root, one result bit per stage, side data carried along
// depends on pis_pkg
module pis_sqrt import pis_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output root_t  out_data
);

    logic                vld_reg  [0:SqrtBits-1];
    logic [Dist2W-1:0]   rem_reg  [0:SqrtBits-1];
    logic [SqrtBits-1:0] q_reg    [0:SqrtBits-1];
    side_t               side_reg [0:SqrtBits-1];
    wire  [SqrtBits:0]   rdy;

    assign rdy[SqrtBits] = out_ready;
    assign in_ready      = rdy[0];

    for (genvar k = 0; k < SqrtBits; k++) begin : g_stage
        localparam int I = SqrtBits - 1 - k;

        logic                vld_in;
        logic [Dist2W-1:0]   rem_in;
        logic [SqrtBits-1:0] q_in;
        side_t               side_in;
        logic [TrialW-1:0]   trial;
        logic                take;
        logic [Dist2W-1:0]   rem_next;
        logic [SqrtBits-1:0] q_next;

        if (k == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = in_data.sect2;
            assign q_in    = '0;
            assign side_in = in_data.side;
        end else begin : g_rest
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // (q + 2^i)^2 - q^2 = q * 2^(i+1) + 2^(2i)
        assign trial    = ({{(TrialW-SqrtBits){1'b0}}, q_in} << (I + 1))
                        + ({{(TrialW-1){1'b0}}, 1'b1} << (2 * I));
        assign take     = {2'b00, rem_in} >= trial;
        assign rem_next = take ? Dist2W'({2'b00, rem_in} - trial) : rem_in;
        assign q_next   = take ? (q_in | (SqrtBits'(1) << I)) : q_in;
        assign rdy[k]   = !vld_reg[k] || rdy[k+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && vld_in) begin
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid       = vld_reg[SqrtBits-1];
    assign out_data.sect_r = q_reg[SqrtBits-1];
    assign out_data.side   = side_reg[SqrtBits-1];

endmodule

// ===== design/pis_range.sv =====
// range test back end: reach sum, reach square, compare and result register (3 stages)
// depends on pis_pkg
module pis_range import pis_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  root_t   in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    typedef struct packed {
        logic [SqrtBits-1:0] reach;
        logic                inside_left_edge;
        logic                inside_right_edge;
        logic [Dist2W-1:0]   dist2;
    } reach_t;

    typedef struct packed {
        logic [Dist2W-1:0] reach2;
        logic              inside_left_edge;
        logic              inside_right_edge;
        logic [Dist2W-1:0] dist2;
    } square_t;

    logic    v1_reg, v2_reg, v3_reg;
    logic    rdy1, rdy2, rdy3;
    reach_t  a_reg, a_next;
    square_t b_reg, b_next;
    result_t r_reg, r_next;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        a_next.reach = in_data.sect_r
                     + {{(SqrtBits-RadiusW){1'b0}}, in_data.side.target_radius};
        a_next.inside_left_edge  = in_data.side.inside_left_edge;
        a_next.inside_right_edge = in_data.side.inside_right_edge;
        a_next.dist2             = in_data.side.dist2;

        b_next.reach2            = a_reg.reach * a_reg.reach;
        b_next.inside_left_edge  = a_reg.inside_left_edge;
        b_next.inside_right_edge = a_reg.inside_right_edge;
        b_next.dist2             = a_reg.dist2;

        // boundary counts as within range
        r_next.inside_left_edge  = b_reg.inside_left_edge;
        r_next.inside_right_edge = b_reg.inside_right_edge;
        r_next.within_range      = b_reg.dist2 <= b_reg.reach2;
        r_next.hit               = b_reg.inside_left_edge && b_reg.inside_right_edge
                                   && (b_reg.dist2 <= b_reg.reach2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) a_reg <= a_next;
        if (rdy2 && v1_reg)   b_reg <= b_next;
        if (rdy3 && v2_reg)   r_reg <= r_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = r_reg;

endmodule

// ===== design/point_in_sector_test_top.sv =====
// top level of the point-in-circular-sector test: stream ports and the three pipeline sections
// depends on pis_pkg, pis_front, pis_sqrt, pis_range
//
// Tests one target circle against a circular sector in the x-z plane per item and
// returns one result item with the left edge flag, the right edge flag, the range
// flag and their AND (hit). Throughput is one item per clock as long as m_tready stays high;
// the pipeline from input to output has 3 front-end stages (differences, 17x17
// products, cross and square sums), 17 square root stages (one root bit per stage,
// this sets the depth) and 3 back-end stages (reach sum, reach square, compare into
// the output register). Every stage has its own valid bit and takes new data whenever
// it is empty or its successor moves, so the input keeps accepting items while a
// result waits on m_tready until all 23 stages are full. No configuration, no state
// carried between items; all arithmetic is exact, with the sector radius taken as
// the floored integer square root of the squared apex-to-left distance.
module point_in_sector_test_top import pis_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // input item
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] apex_x, [31:16] apex_z, [47:32] left_x, [63:48] left_z,
    // [79:64] right_x, [95:80] right_z, [111:96] target_x, [127:112] target_z,
    // [142:128] target_radius, [143] zero
    input  logic [143:0] s_tdata,
    // result item
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] inside_left_edge, [1] inside_right_edge, [2] within_range, [3] hit, [7:4] zero
    output logic [7:0]   m_tdata
);

    query_t  query;
    front_t  front_data;
    root_t   root_data;
    result_t result;
    logic    front_valid, front_ready;
    logic    root_valid, root_ready;

    // unpack the input item, first field in the lowest bits
    assign query.apex_x        = s_tdata[15:0];
    assign query.apex_z        = s_tdata[31:16];
    assign query.left_x        = s_tdata[47:32];
    assign query.left_z        = s_tdata[63:48];
    assign query.right_x       = s_tdata[79:64];
    assign query.right_z       = s_tdata[95:80];
    assign query.target_x      = s_tdata[111:96];
    assign query.target_z      = s_tdata[127:112];
    assign query.target_radius = s_tdata[142:128];

    // differences, products, side flags and squared distances
    pis_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (query),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    // sector radius from the squared apex-to-left distance
    pis_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (root_valid),
        .out_ready (root_ready),
        .out_data  (root_data)
    );

    // range compare, hit and the output register
    pis_range u_range (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (root_valid),
        .in_ready  (root_ready),
        .in_data   (root_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    // pack the result item, first field in the lowest bit
    assign m_tdata = {4'b0000, result.hit, result.within_range,
                      result.inside_right_edge, result.inside_left_edge};

endmodule

// ===== design/pis_checker.sv =====
// port-level checks for the point-in-sector test top, bound to it below
// depends on assert_macros.svh and point_in_sector_test_top
`include "assert_macros.svh"

module pis_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // hit must agree with the three flags it is built from
    `PIS_ASSERT_RST(a_hit_is_and, aclk, aresetn, m_tvalid |-> (m_tdata[3] == (m_tdata[0] && m_tdata[1] && m_tdata[2])), "hit differs from the AND of the flags")

    // a stalled result item holds
    `PIS_ASSERT_RST(a_stall_holds, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result item changed")

    // reset empties the pipeline
    `PIS_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_tvalid, "result valid right after reset")

    // with an empty output stage no stage can hold back the input
    `PIS_ASSERT_RST(a_empty_out_ready, aclk, aresetn, !m_tvalid |-> s_tready, "input stalled while output stage empty")

endmodule

bind point_in_sector_test_top pis_checker u_pis_checker (.*);
